// ===== design/adsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared types, stage and mode codes, register map and fixed-point constants.
// ----------------------------------------------------------------------------
package adsr_pkg;

	localparam int LEVEL_W = 16;  // Q1.15 level, 32768 = 1.0
	localparam int COEFF_W = 17;  // Q1.16 coefficient, 65536 = instant
	localparam int MODE_W  = 2;
	localparam int STAGE_W = 3;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [LEVEL_W-1:0] ENV_FULL        = 16'd32768;
	localparam logic [LEVEL_W-1:0] ENV_ATTACK_DONE = 16'd32441;
	localparam logic [LEVEL_W-1:0] ENV_SNAP        = 16'd327;
	localparam logic [COEFF_W-1:0] ENV_COEFF_MAX   = 17'd65536;

	typedef enum logic [STAGE_W-1:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADSR = 2'd0,
		MODE_AD   = 2'd1,
		MODE_AR   = 2'd2,
		MODE_AHR  = 2'd3
	} mode_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MODE    = 3'd0,
		REG_ATTACK  = 3'd1,
		REG_DECAY   = 3'd2,
		REG_RELEASE = 3'd3,
		REG_SUSTAIN = 3'd4
	} cfg_reg_t;

endpackage

// ===== design/adsr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope channels
// Valid/ready channels for control blocks in and envelope results out.
// ----------------------------------------------------------------------------
interface adsr_ctrl_if;
	logic valid;
	logic ready;
	logic gate_level;
	logic trigger_level;

	modport source (output valid, output gate_level, output trigger_level, input ready);
	modport sink   (input valid, input gate_level, input trigger_level, output ready);
endinterface

interface adsr_env_if;
	logic        valid;
	logic        ready;
	logic [15:0] envelope_value;
	logic [2:0]  envelope_stage;

	modport source (output valid, output envelope_value, output envelope_stage, input ready);
	modport sink   (input valid, input envelope_value, input envelope_stage, output ready);
endinterface

// ===== design/adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator
// Control-rate envelope with ADSR, AD, AR and AHR modes and an APB config port.
// ----------------------------------------------------------------------------
// Each transfer on ctrl is one control block (gate and trigger bits); each
// produces exactly one envelope result on env the next cycle. A new block is
// taken every cycle while the output register is empty or being drained, so
// the sustained rate is one block per clock. The update path is a single
// 16x17 multiply with a rounding add, then compares for the stage change.
// Configuration is written over APB at byte address 4*index and must only be
// changed while no block is in flight.
module adsr_envelope_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	adsr_ctrl_if.sink                     ctrl,
	adsr_env_if.source                    env,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [adsr_pkg::PADDR_W-1:0]  paddr,
	input  logic [adsr_pkg::PDATA_W-1:0]  pwdata,
	output logic [adsr_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import adsr_pkg::*;

	// configuration registers
	mode_t                mode_q;
	logic [COEFF_W-1:0]   attack_q;
	logic [COEFF_W-1:0]   decay_q;
	logic [COEFF_W-1:0]   release_q;
	logic [LEVEL_W-1:0]   sustain_q;

	// envelope state
	stage_t               stage_q;
	logic [LEVEL_W-1:0]   level_q;
	logic                 prev_gate_q;
	logic                 prev_trig_q;

	// result register
	logic                 out_valid_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 accept;

	logic                 gate_on;
	logic                 gate_fall;
	logic                 trig_on;
	stage_t               stage_mid;
	logic [LEVEL_W-1:0]   sus;
	logic [COEFF_W-1:0]   coeff_raw;
	logic [COEFF_W-1:0]   coeff;
	logic [LEVEL_W-1:0]   target;
	logic                 up;
	logic [LEVEL_W-1:0]   diff;
	logic [32:0]          prod;
	logic [33:0]          rounded;
	logic [LEVEL_W-1:0]   step;
	logic [LEVEL_W-1:0]   moved;
	logic [LEVEL_W-1:0]   sus_gap;
	stage_t               stage_nxt;
	logic [LEVEL_W-1:0]   level_nxt;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_ADSR;
			attack_q  <= ENV_COEFF_MAX;
			decay_q   <= ENV_COEFF_MAX;
			release_q <= ENV_COEFF_MAX;
			sustain_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_MODE:    mode_q    <= mode_t'(pwdata[MODE_W-1:0]);
				REG_ATTACK:  attack_q  <= pwdata[COEFF_W-1:0];
				REG_DECAY:   decay_q   <= pwdata[COEFF_W-1:0];
				REG_RELEASE: release_q <= pwdata[COEFF_W-1:0];
				REG_SUSTAIN: sustain_q <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:    prdata = {{(PDATA_W-MODE_W){1'b0}}, mode_q};
			REG_ATTACK:  prdata = {{(PDATA_W-COEFF_W){1'b0}}, attack_q};
			REG_DECAY:   prdata = {{(PDATA_W-COEFF_W){1'b0}}, decay_q};
			REG_RELEASE: prdata = {{(PDATA_W-COEFF_W){1'b0}}, release_q};
			REG_SUSTAIN: prdata = {{(PDATA_W-LEVEL_W){1'b0}}, sustain_q};
			default:     prdata = '0;
		endcase
	end

	// take a new block whenever the result register frees up this cycle
	assign ctrl.ready = !out_valid_q || env.ready;
	assign accept     = ctrl.valid && ctrl.ready;

	assign gate_on   = ctrl.gate_level && !prev_gate_q;
	assign gate_fall = !ctrl.gate_level && prev_gate_q;
	assign trig_on   = ctrl.trigger_level && !prev_trig_q;

	assign sus = (sustain_q > ENV_FULL) ? ENV_FULL : sustain_q;

	// edge handling: any rising edge beats a falling gate
	always_comb begin
		stage_mid = stage_q;
		if (gate_on || trig_on) begin
			stage_mid = ST_ATTACK;
		end else if (gate_fall && stage_q != ST_IDLE && stage_q != ST_RELEASE) begin
			stage_mid = ST_RELEASE;
		end
	end

	// pick target and coefficient for the one shared approach step
	always_comb begin
		case (stage_mid)
			ST_ATTACK: begin
				target    = ENV_FULL;
				coeff_raw = attack_q;
			end
			ST_DECAY: begin
				target    = (mode_q == MODE_AD) ? '0 : sus;
				coeff_raw = decay_q;
			end
			default: begin
				target    = '0;
				coeff_raw = release_q;
			end
		endcase
	end

	assign coeff   = (coeff_raw > ENV_COEFF_MAX) ? ENV_COEFF_MAX : coeff_raw;
	assign up      = target >= level_q;
	assign diff    = up ? (target - level_q) : (level_q - target);
	assign prod    = 33'(diff) * 33'(coeff);
	// round the downward step away from the level so the floor matches
	assign rounded = {1'b0, prod} + (up ? 34'd0 : 34'd65535);
	assign step    = rounded[31:16];
	assign moved   = up ? (level_q + step) : (level_q - step);
	assign sus_gap = (moved >= sus) ? (moved - sus) : (sus - moved);

	always_comb begin
		stage_nxt = stage_mid;
		level_nxt = level_q;
		case (stage_mid)
			ST_ATTACK: begin
				level_nxt = moved;
				if (moved >= ENV_ATTACK_DONE) begin
					level_nxt = ENV_FULL;
					stage_nxt = (mode_q == MODE_ADSR || mode_q == MODE_AD) ?
						ST_DECAY : ST_SUSTAIN;
				end
			end
			ST_DECAY: begin
				level_nxt = moved;
				if (mode_q == MODE_AD) begin
					if (moved <= ENV_SNAP) begin
						level_nxt = '0;
						stage_nxt = ST_IDLE;
					end
				end else if (sus_gap <= ENV_SNAP) begin
					level_nxt = sus;
					stage_nxt = ST_SUSTAIN;
				end
			end
			ST_SUSTAIN: begin
				// AD only lands here after a mode change: hold the level
				if (mode_q == MODE_ADSR) begin
					level_nxt = sus;
				end else if (mode_q == MODE_AR || mode_q == MODE_AHR) begin
					level_nxt = ENV_FULL;
				end
			end
			ST_RELEASE: begin
				level_nxt = moved;
				if (moved <= ENV_SNAP) begin
					level_nxt = '0;
					stage_nxt = ST_IDLE;
				end
			end
			default: begin
				level_nxt = '0;
				stage_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= ST_IDLE;
			level_q     <= '0;
			prev_gate_q <= 1'b0;
			prev_trig_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				stage_q     <= stage_nxt;
				level_q     <= level_nxt;
				prev_gate_q <= ctrl.gate_level;
				prev_trig_q <= ctrl.trigger_level;
				out_valid_q <= 1'b1;
			end else if (env.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// the state registers double as the result payload
	assign env.valid          = out_valid_q;
	assign env.envelope_value = level_q;
	assign env.envelope_stage = stage_q;

endmodule

// ===== test/tb_adsr_envelope_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator testbench
// Streams gate/trigger control blocks through the block under random source
// gaps and sink stalls, reprograms the envelope registers over APB between
// phases, and checks every envelope result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_generator;
	import adsr_pkg::*;

	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned RANDOM_BLOCKS = 1000;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd6;

	typedef struct {
		logic gate;
		logic trig;
	} ctrl_block_t;

	typedef struct {
		logic [LEVEL_W-1:0] value;
		stage_t             stage;
	} env_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	adsr_ctrl_if ctrl_bus ();
	adsr_env_if  env_bus ();

	adsr_envelope_generator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_bus),
		.env     (env_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// predictor copy of the register file and the envelope state
	mode_t              cfg_mode;
	logic [COEFF_W-1:0] cfg_attack;
	logic [COEFF_W-1:0] cfg_decay;
	logic [COEFF_W-1:0] cfg_release;
	logic [LEVEL_W-1:0] cfg_sustain;
	stage_t             env_stage;
	int unsigned        env_level;
	logic               gate_prev;
	logic               last_trig;

	ctrl_block_t block_queue[$];
	env_result_t env_expected[$];
	ctrl_block_t drive_blk;
	env_result_t want;
	logic ctrl_taken;
	logic env_taken;
	int unsigned src_wait;
	int unsigned snk_wait;
	bit src_quiet;
	bit snk_quiet;
	int unsigned idle_cycles;
	int unsigned mismatch_count;
	int unsigned random_blocks;

	// level + floor((target - level) * coeff / 2^16), coefficient capped at instant
	function automatic int unsigned approach_level(input int unsigned lvl,
		input int unsigned tgt, input logic [COEFF_W-1:0] coeff);
		longint unsigned c;
		c = 64'((coeff > ENV_COEFF_MAX) ? ENV_COEFF_MAX : coeff);
		if (tgt >= lvl) begin
			return lvl + int'((longint'(tgt - lvl) * c) >> 16);
		end
		return lvl - int'((longint'(lvl - tgt) * c + 65535) >> 16);
	endfunction

	function automatic void advance_envelope(input logic gate, input logic trig);
		int unsigned hold_lvl;
		int unsigned diff;
		logic gate_rise;
		logic gate_fall;
		logic trig_rise;
		hold_lvl = 32'((cfg_sustain > ENV_FULL) ? ENV_FULL : cfg_sustain);
		gate_rise = gate && !gate_prev;
		gate_fall = !gate && gate_prev;
		trig_rise = trig && !last_trig;
		gate_prev = gate;
		last_trig = trig;

		// any rising edge wins over a falling gate
		if (gate_rise || trig_rise)
			env_stage = ST_ATTACK;
		else if (gate_fall && env_stage != ST_IDLE && env_stage != ST_RELEASE)
			env_stage = ST_RELEASE;

		case (env_stage)
			ST_ATTACK: begin
				env_level = approach_level(env_level, 32'(ENV_FULL), cfg_attack);
				if (env_level >= ENV_ATTACK_DONE) begin
					env_level = 32'(ENV_FULL);
					env_stage = (cfg_mode == MODE_ADSR || cfg_mode == MODE_AD) ?
						ST_DECAY : ST_SUSTAIN;
				end
			end
			ST_DECAY: begin
				if (cfg_mode == MODE_AD) begin
					env_level = approach_level(env_level, 0, cfg_decay);
					if (env_level <= ENV_SNAP) begin
						env_level = 0;
						env_stage = ST_IDLE;
					end
				end else begin
					env_level = approach_level(env_level, hold_lvl, cfg_decay);
					diff = (env_level >= hold_lvl) ? env_level - hold_lvl : hold_lvl - env_level;
					if (diff <= ENV_SNAP) begin
						env_level = hold_lvl;
						env_stage = ST_SUSTAIN;
					end
				end
			end
			ST_SUSTAIN: begin
				// AD only lands here after a mode change: keep the level
				if (cfg_mode == MODE_ADSR)
					env_level = hold_lvl;
				else if (cfg_mode == MODE_AR || cfg_mode == MODE_AHR)
					env_level = 32'(ENV_FULL);
			end
			ST_RELEASE: begin
				env_level = approach_level(env_level, 0, cfg_release);
				if (env_level <= ENV_SNAP) begin
					env_level = 0;
					env_stage = ST_IDLE;
				end
			end
			default: begin
				env_stage = ST_IDLE;
				env_level = 0;
			end
		endcase
	endfunction

	function automatic int unsigned draw_wait(inout bit quiet);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 6);
	endfunction

	// control block source
	always @(negedge clk) begin
		if (!arst_n) begin
			ctrl_bus.valid <= 1'b0;
		end else if (ctrl_bus.valid && !ctrl_taken) begin
			// hold until the transfer
		end else if (src_wait > 0) begin
			ctrl_bus.valid <= 1'b0;
			src_wait = src_wait - 1;
		end else if (block_queue.size() > 0) begin
			drive_blk = block_queue.pop_front();
			ctrl_bus.gate_level <= drive_blk.gate;
			ctrl_bus.trigger_level <= drive_blk.trig;
			ctrl_bus.valid <= 1'b1;
			src_wait = draw_wait(src_quiet);
		end else begin
			ctrl_bus.valid <= 1'b0;
		end
	end

	// envelope result sink
	always @(negedge clk) begin
		if (!arst_n) begin
			env_bus.ready <= 1'b0;
		end else begin
			if (env_taken)
				snk_wait = draw_wait(snk_quiet);
			if (snk_wait > 0) begin
				env_bus.ready <= 1'b0;
				snk_wait = snk_wait - 1;
			end else begin
				env_bus.ready <= 1'b1;
			end
		end
	end

	// predict on every control transfer, check on every result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			ctrl_taken <= ctrl_bus.valid && ctrl_bus.ready;
			env_taken <= env_bus.valid && env_bus.ready;
			if (ctrl_bus.valid && ctrl_bus.ready) begin
				advance_envelope(ctrl_bus.gate_level, ctrl_bus.trigger_level);
				env_expected.push_back('{value: env_level[LEVEL_W-1:0], stage: env_stage});
			end
			if (env_bus.valid && env_bus.ready) begin
				if (env_expected.size() == 0) begin
					$display("%0t unexpected envelope result: value %0d stage %0d", $time,
						env_bus.envelope_value, env_bus.envelope_stage);
					mismatch_count++;
				end else begin
					want = env_expected.pop_front();
					if (env_bus.envelope_value !== want.value) begin
						$display("%0t envelope_value mismatch: expected %0d, got %0d", $time,
							want.value, env_bus.envelope_value);
						mismatch_count++;
					end
					if (env_bus.envelope_stage !== want.stage) begin
						$display("%0t envelope_stage mismatch: expected %0d, got %0d", $time,
							want.stage, env_bus.envelope_stage);
						mismatch_count++;
					end
				end
			end
			if ((ctrl_bus.valid && ctrl_bus.ready) || (env_bus.valid && env_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MODE:    cfg_mode = mode_t'(data[MODE_W-1:0]);
			REG_ATTACK:  cfg_attack = data[COEFF_W-1:0];
			REG_DECAY:   cfg_decay = data[COEFF_W-1:0];
			REG_RELEASE: cfg_release = data[COEFF_W-1:0];
			REG_SUSTAIN: cfg_sustain = data[LEVEL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_config(input mode_t mode, input int unsigned atk, input int unsigned dcy,
		input int unsigned rel, input int unsigned sus);
		apb_write(REG_MODE, PDATA_W'(mode));
		apb_write(REG_ATTACK, atk);
		apb_write(REG_DECAY, dcy);
		apb_write(REG_RELEASE, rel);
		apb_write(REG_SUSTAIN, sus);
	endtask

	task automatic wait_drained();
		while (block_queue.size() != 0 || ctrl_bus.valid || env_expected.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic queue_block(input logic gate, input logic trig);
		block_queue.push_back('{gate: gate, trig: trig});
	endtask

	function automatic int unsigned pick_coeff();
		case ($urandom_range(0, 11))
			0:       return 0;
			1, 2:    return 32'(ENV_COEFF_MAX);
			3:       return $urandom_range(65537, 131071);
			default: return $urandom_range(1500, 40000);
		endcase
	endfunction

	function automatic int unsigned pick_sustain();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 32'(ENV_FULL);
			2:       return $urandom_range(32769, 65535);
			default: return $urandom_range(0, 32768);
		endcase
	endfunction

	// gate held for a while with the odd trigger, then let go
	task automatic queue_note();
		int unsigned on_len;
		int unsigned off_len;
		on_len = $urandom_range(1, 60);
		off_len = $urandom_range(1, 50);
		for (int i = 0; i < on_len; i++)
			queue_block(1'b1, $urandom_range(0, 15) == 0);
		for (int i = 0; i < off_len; i++)
			queue_block(1'b0, $urandom_range(0, 19) == 0);
		random_blocks += on_len + off_len;
	endtask

	task automatic queue_hit();
		int unsigned tail;
		tail = $urandom_range(1, 40);
		queue_block(1'b0, 1'b1);
		for (int i = 0; i < tail; i++)
			queue_block(1'b0, 1'b0);
		random_blocks += tail + 1;
	endtask

	task automatic queue_noise();
		int unsigned len;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++)
			queue_block(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		random_blocks += len;
	endtask

	initial begin
		int unsigned phase_len;
		int unsigned phase_start;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		ctrl_bus.valid = 1'b0;
		ctrl_bus.gate_level = 1'b0;
		ctrl_bus.trigger_level = 1'b0;
		env_bus.ready = 1'b0;
		ctrl_taken = 1'b0;
		env_taken = 1'b0;
		src_wait = 0;
		snk_wait = 0;
		src_quiet = 1'b0;
		snk_quiet = 1'b0;
		idle_cycles = 0;
		mismatch_count = 0;
		random_blocks = 0;
		cfg_mode = MODE_ADSR;
		cfg_attack = ENV_COEFF_MAX;
		cfg_decay = ENV_COEFF_MAX;
		cfg_release = ENV_COEFF_MAX;
		cfg_sustain = '0;
		env_stage = ST_IDLE;
		env_level = 0;
		gate_prev = 1'b0;
		last_trig = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: instant ADSR to zero sustain, then edge collisions
		queue_block(1'b0, 1'b0);
		queue_block(1'b1, 1'b0);
		queue_block(1'b1, 1'b0);
		queue_block(1'b1, 1'b0);
		queue_block(1'b0, 1'b1);
		queue_block(1'b0, 1'b0);
		queue_block(1'b1, 1'b1);
		queue_block(1'b0, 1'b0);
		wait_drained();

		// AD with saturated coefficients and sustain, plus a write to a hole in the map
		write_config(MODE_AD, 131071, 32'(ENV_COEFF_MAX), 100000, 32'hFFFF);
		apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
		queue_block(1'b1, 1'b0);
		queue_block(1'b1, 1'b0);
		queue_block(1'b1, 1'b0);
		queue_block(1'b0, 1'b0);
		wait_drained();

		// AR with a frozen attack; trigger leaves it parked in attack
		write_config(MODE_AR, 0, 0, 0, 32'(ENV_FULL));
		queue_block(1'b1, 1'b0);
		queue_block(1'b0, 1'b0);
		queue_block(1'b0, 1'b1);
		wait_drained();

		// switch to AHR mid-attack, leave it mid-release
		write_config(MODE_AHR, 30000, 0, 9000, 40000);
		queue_block(1'b1, 1'b0);
		queue_block(1'b1, 1'b0);
		queue_block(1'b0, 1'b0);
		wait_drained();

		// ADSR into sustain, then AD holds the sustain level
		write_config(MODE_ADSR, 32'(ENV_COEFF_MAX), 32'(ENV_COEFF_MAX), 20000, 16384);
		queue_block(1'b1, 1'b0);
		queue_block(1'b1, 1'b0);
		queue_block(1'b1, 1'b0);
		wait_drained();
		apb_write(REG_MODE, PDATA_W'(MODE_AD));
		queue_block(1'b1, 1'b0);
		queue_block(1'b0, 1'b0);
		wait_drained();

		while (random_blocks < RANDOM_BLOCKS) begin
			write_config(mode_t'($urandom_range(0, 3)), pick_coeff(), pick_coeff(),
				pick_coeff(), pick_sustain());
			phase_len = $urandom_range(60, 140);
			phase_start = random_blocks;
			while (random_blocks - phase_start < phase_len) begin
				case ($urandom_range(0, 9))
					0:       queue_noise();
					1:       queue_hit();
					default: queue_note();
				endcase
			end
			wait_drained();
		end

		repeat (5) @(negedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
